@@ hw/rtl/pbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg: shared types and constants for the post-blend dither stage
// Register map codes, the register set record and the records passed
// between the pipeline stages.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // Configuration port geometry: 64-bit data, registers at 8-byte spacing.
  localparam int DataW = 64;
  localparam int AddrW = 6;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MODE_FLAGS    = 3'd0;
  localparam logic [2:0] REG_BLEND_SELECT  = 3'd1;
  localparam logic [2:0] REG_BLEND_FIX     = 3'd2;
  localparam logic [2:0] REG_SOURCE_COLOR  = 3'd3;
  localparam logic [2:0] REG_DITHER_MATRIX = 3'd4;

  // Operand select codes for A, B and D.
  localparam logic [1:0] SEL_SOURCE = 2'd0;
  localparam logic [1:0] SEL_DEST   = 2'd1;

  // Scan mask modes.
  localparam logic [1:0] SCAN_OFF = 2'd0;
  localparam logic [1:0] SCAN_ODD = 2'd3;

  // Mode flag bit positions.
  localparam int MODE_DITHER = 2;
  localparam int MODE_BLEND  = 3;
  localparam int MODE_HALVE  = 4;
  localparam int MODE_FMT32  = 5;

  // Channel count and blend shift.
  localparam int NumCh      = 3;
  localparam int BlendShift = 7;

  // Register set.
  typedef struct packed {
    logic [5:0]  mode_flags;
    logic [7:0]  blend_select;
    logic [7:0]  blend_fix;
    logic [31:0] source_color;
    logic [47:0] dither_matrix;
  } cfg_t;

  // Per-pixel control that rides through every stage.
  typedef struct packed {
    logic                  hidden;
    logic                  no_write;
    logic                  blend_en;
    logic                  dither_en;
    logic                  halve_en;
    logic [2:0]            dither_val;
    logic [NumCh-1:0][7:0] addend;
    logic [31:0]           old_frame;
    logic [31:0]           old_depth;
    logic [31:0]           drawn;
  } ctl_t;

  // Stage 1 output: blend operands.
  typedef struct packed {
    ctl_t                  ctl;
    logic [NumCh-1:0][8:0] diff;
    logic [7:0]            factor;
  } prep_t;

  // Stage 2 output: blend products.
  typedef struct packed {
    ctl_t                   ctl;
    logic [NumCh-1:0][17:0] prod;
  } mult_t;

endpackage

@@ hw/rtl/pixel_post_blend_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_post_blend_dither: per-pixel write-back after a draw
// Scan-mask restore, wrapping blend recompute, ordered dither and halving
// of the drawn RGB, with the write decision for frame and depth.
//
//   channel   handshake             payload
//   pixel     pix_valid/pix_stall   col_phase row_phase old_frame old_depth
//                                   drawn_frame
//   result    res_valid/res_stall   frame_write frame_value depth_write
//                                   depth_value
//   config    APB psel/penable      paddr pwdata prdata pready
//
// One request enters per cycle while no result stall holds it back; its result
// passes through three register stages (operand select, multiply, finish into
// the output register). The multiplier stage sets the cycle time.
// Synchronous reset clears the config registers and all stage valid bits.
// A stall on the result side holds each full stage; empty stages still fill.
// ----------------------------------------------------------------------------
module pixel_post_blend_dither (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pbd_pkg::AddrW-1:0] paddr,
  input  logic [pbd_pkg::DataW-1:0] pwdata,
  output logic [pbd_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  logic [1:0]                col_phase,
  input  logic [1:0]                row_phase,
  input  logic [31:0]               old_frame,
  input  logic [31:0]               old_depth,
  input  logic [31:0]               drawn_frame,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic                      frame_write,
  output logic [31:0]               frame_value,
  output logic                      depth_write,
  output logic [31:0]               depth_value
);

  pbd_pkg::cfg_t  cfg;
  pbd_pkg::prep_t prep_data;
  pbd_pkg::mult_t mult_data;
  logic           pix_ready;
  logic           prep_valid;
  logic           prep_ready;
  logic           mult_valid;
  logic           mult_ready;

  assign pix_stall = !pix_ready;

  // Configuration registers.
  pbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1: decode and operand select.
  pbd_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (pix_valid),
    .in_ready    (pix_ready),
    .col_phase   (col_phase),
    .row_phase   (row_phase),
    .old_frame   (old_frame),
    .old_depth   (old_depth),
    .drawn_frame (drawn_frame),
    .out_valid   (prep_valid),
    .out_ready   (prep_ready),
    .out_data    (prep_data)
  );

  // Stage 2: blend multiply.
  pbd_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (mult_valid),
    .out_ready (mult_ready),
    .out_data  (mult_data)
  );

  // Stage 3: finish into the output register.
  pbd_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mult_valid),
    .in_ready    (mult_ready),
    .in_data     (mult_data),
    .out_valid   (res_valid),
    .out_ready   (!res_stall),
    .frame_write (frame_write),
    .frame_value (frame_value),
    .depth_write (depth_write),
    .depth_value (depth_value)
  );

  // A depth restore only comes with a frame restore.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && depth_write |-> frame_write)
    else $error("depth written without frame");

  // Fields not written read as zero.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !frame_write |-> frame_value == 32'd0)
    else $error("frame value nonzero without write");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && !depth_write |-> depth_value == 32'd0)
    else $error("depth value nonzero without write");

  // With the result side free, every stage can move, so no request is refused.
  assert property (@(posedge clk) disable iff (rst)
    !res_stall |-> !pix_stall)
    else $error("input stalled while output free");

endmodule

@@ hw/rtl/pbd_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_regs: configuration register file
// APB-style slave holding the blend, dither and mode registers.
// ----------------------------------------------------------------------------
module pbd_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [pbd_pkg::AddrW-1:0] paddr,
  input  logic [pbd_pkg::DataW-1:0] pwdata,
  output logic [pbd_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output pbd_pkg::cfg_t            cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pbd_pkg::AddrW-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        pbd_pkg::REG_MODE_FLAGS:    cfg.mode_flags    <= pwdata[5:0];
        pbd_pkg::REG_BLEND_SELECT:  cfg.blend_select  <= pwdata[7:0];
        pbd_pkg::REG_BLEND_FIX:     cfg.blend_fix     <= pwdata[7:0];
        pbd_pkg::REG_SOURCE_COLOR:  cfg.source_color  <= pwdata[31:0];
        pbd_pkg::REG_DITHER_MATRIX: cfg.dither_matrix <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      pbd_pkg::REG_MODE_FLAGS:    prdata = {58'd0, cfg.mode_flags};
      pbd_pkg::REG_BLEND_SELECT:  prdata = {56'd0, cfg.blend_select};
      pbd_pkg::REG_BLEND_FIX:     prdata = {56'd0, cfg.blend_fix};
      pbd_pkg::REG_SOURCE_COLOR:  prdata = {32'd0, cfg.source_color};
      pbd_pkg::REG_DITHER_MATRIX: prdata = {16'd0, cfg.dither_matrix};
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/pbd_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_prep: pipeline stage 1
// Decodes scan masking and write skipping, picks blend operands, forms A-B
// per channel and looks up the dither value.
// ----------------------------------------------------------------------------
module pbd_prep (
  input  logic           clk,
  input  logic           rst,
  input  pbd_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     col_phase,
  input  logic [1:0]     row_phase,
  input  logic [31:0]    old_frame,
  input  logic [31:0]    old_depth,
  input  logic [31:0]    drawn_frame,
  output logic           out_valid,
  input  logic           out_ready,
  output pbd_pkg::prep_t out_data
);

  pbd_pkg::prep_t data_next;
  logic           hidden;
  logic [1:0]     scan;
  logic [3:0]     dith_idx;
  logic [5:0]     dith_pos;
  logic [1:0]     sel_a;
  logic [1:0]     sel_b;
  logic [1:0]     sel_c;
  logic [1:0]     sel_d;

  assign in_ready = !out_valid || out_ready;

  assign scan  = cfg.mode_flags[1:0];
  assign sel_a = cfg.blend_select[1:0];
  assign sel_b = cfg.blend_select[3:2];
  assign sel_c = cfg.blend_select[5:4];
  assign sel_d = cfg.blend_select[7:6];
  assign dith_idx = {row_phase, col_phase};

  // Bit position of the matrix entry: three bits per entry.
  assign dith_pos = {1'b0, dith_idx, 1'b0} + {2'b00, dith_idx};

  // Scan mask: odd rows hidden in one mode, even rows in the other two.
  always_comb begin
    case (scan)
      pbd_pkg::SCAN_OFF: hidden = 1'b0;
      pbd_pkg::SCAN_ODD: hidden = row_phase[0];
      default:           hidden = !row_phase[0];
    endcase
  end

  // Operand selection and per-channel difference.
  always_comb begin
    logic [7:0] s;
    logic [7:0] d;
    logic [7:0] a;
    logic [7:0] b;
    data_next = '0;
    data_next.ctl.hidden     = hidden;
    data_next.ctl.no_write   = (drawn_frame == old_frame) ||
                               !cfg.mode_flags[pbd_pkg::MODE_FMT32];
    data_next.ctl.blend_en   = cfg.mode_flags[pbd_pkg::MODE_BLEND];
    data_next.ctl.dither_en  = cfg.mode_flags[pbd_pkg::MODE_DITHER];
    data_next.ctl.halve_en   = cfg.mode_flags[pbd_pkg::MODE_HALVE];
    data_next.ctl.dither_val = cfg.dither_matrix[dith_pos +: 3];
    data_next.ctl.old_frame  = old_frame;
    data_next.ctl.old_depth  = old_depth;
    data_next.ctl.drawn      = drawn_frame;
    case (sel_c)
      pbd_pkg::SEL_SOURCE: data_next.factor = cfg.source_color[31:24];
      pbd_pkg::SEL_DEST:   data_next.factor = old_frame[31:24];
      default:             data_next.factor = cfg.blend_fix;
    endcase
    for (int i = 0; i < pbd_pkg::NumCh; i++) begin
      s = cfg.source_color[8*i +: 8];
      d = old_frame[8*i +: 8];
      case (sel_a)
        pbd_pkg::SEL_SOURCE: a = s;
        pbd_pkg::SEL_DEST:   a = d;
        default:             a = 8'd0;
      endcase
      case (sel_b)
        pbd_pkg::SEL_SOURCE: b = s;
        pbd_pkg::SEL_DEST:   b = d;
        default:             b = 8'd0;
      endcase
      case (sel_d)
        pbd_pkg::SEL_SOURCE: data_next.ctl.addend[i] = s;
        pbd_pkg::SEL_DEST:   data_next.ctl.addend[i] = d;
        default:             data_next.ctl.addend[i] = 8'd0;
      endcase
      data_next.diff[i] = {1'b0, a} - {1'b0, b};
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ hw/rtl/pbd_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_mult: pipeline stage 2
// Multiplies each channel difference by the blend factor, one small signed
// multiplier per channel.
// ----------------------------------------------------------------------------
module pbd_mult (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbd_pkg::prep_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbd_pkg::mult_t out_data
);

  pbd_pkg::mult_t data_next;

  assign in_ready = !out_valid || out_ready;

  // Signed (A-B) times unsigned factor.
  always_comb begin
    logic signed [8:0]  dif;
    logic signed [8:0]  fac;
    logic signed [17:0] prd;
    data_next     = '0;
    data_next.ctl = in_data.ctl;
    fac = $signed({1'b0, in_data.factor});
    for (int i = 0; i < pbd_pkg::NumCh; i++) begin
      dif = $signed(in_data.diff[i]);
      prd = 18'(dif) * 18'(fac);
      data_next.prod[i] = prd;
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

@@ hw/rtl/pbd_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_finish: pipeline stage 3 and output register
// Floors the product by 128, adds D with wrap, applies saturating dither
// and halving, and decides which words get written.
// ----------------------------------------------------------------------------
module pbd_finish (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbd_pkg::mult_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           frame_write,
  output logic [31:0]    frame_value,
  output logic           depth_write,
  output logic [31:0]    depth_value
);

  logic [31:0] result;
  logic        fw_next;
  logic [31:0] fv_next;

  assign in_ready = !out_valid || out_ready;

  // Channel post-processing; alpha passes through.
  always_comb begin
    logic signed [17:0] prd;
    logic signed [17:0] shifted;
    logic [7:0]         ch;
    logic [8:0]         dsum;
    result = in_data.ctl.drawn;
    for (int i = 0; i < pbd_pkg::NumCh; i++) begin
      prd     = $signed(in_data.prod[i]);
      shifted = prd >>> pbd_pkg::BlendShift;
      ch      = in_data.ctl.drawn[8*i +: 8];
      if (in_data.ctl.blend_en) begin
        ch = shifted[7:0] + in_data.ctl.addend[i];
      end
      dsum = {1'b0, ch} + {6'd0, in_data.ctl.dither_val};
      if (in_data.ctl.dither_en) begin
        ch = dsum[8] ? 8'hFF : dsum[7:0];
      end
      if (in_data.ctl.halve_en) begin
        ch = {1'b0, ch[7:1]};
      end
      result[8*i +: 8] = ch;
    end
  end

  // Write decision: hidden rows restore, otherwise write only a changed word.
  always_comb begin
    if (in_data.ctl.hidden) begin
      fw_next = 1'b1;
      fv_next = in_data.ctl.old_frame;
    end else if (!in_data.ctl.no_write && (result != in_data.ctl.drawn)) begin
      fw_next = 1'b1;
      fv_next = result;
    end else begin
      fw_next = 1'b0;
      fv_next = '0;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      frame_write <= fw_next;
      frame_value <= fv_next;
      depth_write <= in_data.ctl.hidden;
      depth_value <= in_data.ctl.hidden ? in_data.ctl.old_depth : 32'd0;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pixel post-blend dither stage
// Pixel requests with biased random content go in through the valid/stall
// port while the result side stalls at random. A scoreboard predicts every
// write-back from its own copy of the register set and compares each
// returned result field by field. Registers are loaded through the APB
// port between phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import pbd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int PIPE_DEPTH   = 4;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int PRINT_CAP    = 50;
  localparam longint WATCHDOG_NS = 64'd10_000_000;

  // Select and scan codes not named in the package.
  localparam logic [1:0] SEL_ZERO    = 2'd2;
  localparam logic [1:0] SEL_FIX     = 2'd2;
  localparam logic [1:0] SCAN_EVEN_A = 2'd1;
  localparam logic [1:0] SCAN_EVEN_B = 2'd2;

  typedef struct packed {
    logic [1:0]  col_phase;
    logic [1:0]  row_phase;
    logic [31:0] old_frame;
    logic [31:0] old_depth;
    logic [31:0] drawn_frame;
  } pixel_t;

  typedef struct packed {
    logic        frame_write;
    logic [31:0] frame_value;
    logic        depth_write;
    logic [31:0] depth_value;
  } writeback_t;

  // Predicts write-backs and holds the ones still owed by the block.
  class writeback_checker;
    cfg_t       cfg;
    writeback_t expected_writebacks[$];
    int         mismatches;

    function new();
      cfg = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [63:0] value);
      case (idx)
        REG_MODE_FLAGS:    cfg.mode_flags    = value[5:0];
        REG_BLEND_SELECT:  cfg.blend_select  = value[7:0];
        REG_BLEND_FIX:     cfg.blend_fix     = value[7:0];
        REG_SOURCE_COLOR:  cfg.source_color  = value[31:0];
        REG_DITHER_MATRIX: cfg.dither_matrix = value[47:0];
        default: ;
      endcase
    endfunction

    function int pick_operand(logic [1:0] sel, int src, int dst);
      if (sel == SEL_SOURCE) return src;
      if (sel == SEL_DEST) return dst;
      return 0;
    endfunction

    function writeback_t predict_writeback(pixel_t p);
      writeback_t w;
      logic [1:0] scan;
      logic       hidden;
      logic [7:0] ch [NumCh];
      logic [8:0] sum;
      logic [2:0] dv;
      logic [31:0] word;
      int s, d, a, b, c, dd, prod, v, idx;
      w = '0;
      scan = cfg.mode_flags[1:0];
      if (scan == SCAN_OFF) hidden = 1'b0;
      else if (scan == SCAN_ODD) hidden = p.row_phase[0];
      else hidden = !p.row_phase[0];
      // A masked row gets its old words back, whatever the format.
      if (hidden) begin
        w.frame_write = 1'b1;
        w.frame_value = p.old_frame;
        w.depth_write = 1'b1;
        w.depth_value = p.old_depth;
        return w;
      end
      if (p.drawn_frame == p.old_frame || !cfg.mode_flags[MODE_FMT32]) return w;
      for (int i = 0; i < NumCh; i++) ch[i] = p.drawn_frame[8*i +: 8];
      // Wrapping blend: ((A - B) * C) floored by 128, plus D, low byte kept.
      if (cfg.mode_flags[MODE_BLEND]) begin
        case (cfg.blend_select[5:4])
          SEL_SOURCE: c = cfg.source_color[31:24];
          SEL_DEST:   c = p.old_frame[31:24];
          default:    c = cfg.blend_fix;
        endcase
        for (int i = 0; i < NumCh; i++) begin
          s = cfg.source_color[8*i +: 8];
          d = p.old_frame[8*i +: 8];
          a = pick_operand(cfg.blend_select[1:0], s, d);
          b = pick_operand(cfg.blend_select[3:2], s, d);
          dd = pick_operand(cfg.blend_select[7:6], s, d);
          prod = (a - b) * c;
          v = (prod >>> BlendShift) + dd;
          ch[i] = v[7:0];
        end
      end
      // Ordered dither with saturation at full scale.
      if (cfg.mode_flags[MODE_DITHER]) begin
        idx = p.row_phase * 4 + p.col_phase;
        dv = cfg.dither_matrix[3*idx +: 3];
        for (int i = 0; i < NumCh; i++) begin
          sum = {1'b0, ch[i]} + dv;
          ch[i] = sum[8] ? 8'hFF : sum[7:0];
        end
      end
      if (cfg.mode_flags[MODE_HALVE]) begin
        for (int i = 0; i < NumCh; i++) ch[i] = ch[i] >> 1;
      end
      word = {p.drawn_frame[31:24], ch[2], ch[1], ch[0]};
      // The pixel already holds the drawn word, so an equal result is not written.
      if (word != p.drawn_frame) begin
        w.frame_write = 1'b1;
        w.frame_value = word;
      end
      return w;
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void note_pixel(pixel_t p);
      expected_writebacks.push_back(predict_writeback(p));
    endfunction

    task check_writeback(writeback_t got);
      writeback_t want;
      if (expected_writebacks.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = expected_writebacks.pop_front();
      if (got.frame_write !== want.frame_write)
        report_mismatch($sformatf("frame_write %0b, expected %0b",
                                  got.frame_write, want.frame_write));
      if (got.frame_value !== want.frame_value)
        report_mismatch($sformatf("frame_value %h, expected %h",
                                  got.frame_value, want.frame_value));
      if (got.depth_write !== want.depth_write)
        report_mismatch($sformatf("depth_write %0b, expected %0b",
                                  got.depth_write, want.depth_write));
      if (got.depth_value !== want.depth_value)
        report_mismatch($sformatf("depth_value %h, expected %h",
                                  got.depth_value, want.depth_value));
    endtask

    function int pending();
      return expected_writebacks.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              pix_valid = 1'b0;
  logic              pix_stall;
  logic [1:0]        col_phase = '0;
  logic [1:0]        row_phase = '0;
  logic [31:0]       old_frame = '0;
  logic [31:0]       old_depth = '0;
  logic [31:0]       drawn_frame = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic              frame_write;
  logic [31:0]       frame_value;
  logic              depth_write;
  logic [31:0]       depth_value;

  writeback_checker sb = new();
  bit source_busy = 1'b1;
  bit sink_busy = 1'b1;
  bit hold_req = 1'b0;

  pixel_post_blend_dither dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .col_phase   (col_phase),
    .row_phase   (row_phase),
    .old_frame   (old_frame),
    .old_depth   (old_depth),
    .drawn_frame (drawn_frame),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .frame_write (frame_write),
    .frame_value (frame_value),
    .depth_write (depth_write),
    .depth_value (depth_value)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watch both handshakes at every edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall)
        sb.note_pixel('{col_phase, row_phase, old_frame, old_depth, drawn_frame});
      if (res_valid && !res_stall)
        sb.check_writeback('{frame_write, frame_value, depth_write, depth_value});
    end
  end

  function automatic logic [5:0] mode_word(logic [1:0] scan, bit fmt32, bit blend,
                                           bit dither, bit halve);
    logic [5:0] w;
    w = '0;
    w[1:0] = scan;
    w[MODE_FMT32] = fmt32;
    w[MODE_BLEND] = blend;
    w[MODE_DITHER] = dither;
    w[MODE_HALVE] = halve;
    return w;
  endfunction

  function automatic logic [7:0] blend_word(logic [1:0] a, logic [1:0] b, logic [1:0] c,
                                            logic [1:0] d);
    return {d, c, b, a};
  endfunction

  // Byte values weighted toward the saturation and wrap edges.
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 40) return 8'(8'hF8 + $urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  function automatic pixel_t make_pixel();
    pixel_t p;
    int r;
    p.col_phase = 2'($urandom);
    p.row_phase = 2'($urandom);
    p.old_frame = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    p.old_depth = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) p.drawn_frame = p.old_frame;
    else if (r < 20) p.drawn_frame = {rand_byte(), p.old_frame[23:0]};
    else p.drawn_frame = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!source_busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Offer one request and hold it until it is taken; valid stays high after.
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid   <= 1'b1;
    col_phase   <= p.col_phase;
    row_phase   <= p.row_phase;
    old_frame   <= p.old_frame;
    old_depth   <= p.old_depth;
    drawn_frame <= p.drawn_frame;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic send_fields(input logic [1:0] col, input logic [1:0] row,
                             input logic [31:0] oldf, input logic [31:0] oldd,
                             input logic [31:0] drawn);
    send_pixel('{col, row, oldf, oldd, drawn});
  endtask

  // Stop offering and let every outstanding request come back.
  task automatic wait_idle();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [5:0] mode, input logic [7:0] sel,
                           input logic [7:0] fix, input logic [31:0] color,
                           input logic [47:0] matrix);
    wait_idle();
    reg_write(REG_MODE_FLAGS, 64'(mode));
    reg_write(REG_BLEND_SELECT, 64'(sel));
    reg_write(REG_BLEND_FIX, 64'(fix));
    reg_write(REG_SOURCE_COLOR, 64'(color));
    reg_write(REG_DITHER_MATRIX, 64'(matrix));
  endtask

  task automatic load_random_regs();
    logic [5:0]  mode;
    logic [7:0]  fix;
    logic [63:0] m;
    int r;
    mode = 6'($urandom);
    r = $urandom_range(0, 9);
    // Most settings leave every row visible with a 32-bit frame.
    if (r < 6) begin
      mode[1:0] = SCAN_OFF;
      mode[MODE_FMT32] = 1'b1;
    end
    r = $urandom_range(0, 9);
    fix = (r < 2) ? 8'h00 : (r < 4) ? 8'hFF : 8'($urandom);
    m = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) m = '1;
    load_regs(mode, 8'($urandom), fix,
              {rand_byte(), rand_byte(), rand_byte(), rand_byte()}, m[47:0]);
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off.
  initial begin : result_sink
    int pick;
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (!sink_busy || pick < 50) begin
          res_stall <= 1'b0;
          span = $urandom_range(1, 16);
        end else if (pick < 85) begin
          res_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (pick < 97) begin
          res_stall <= 1'b1;
          span = $urandom_range(4, 12);
        end else begin
          res_stall <= 1'b1;
          span = $urandom_range(20, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int waited;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: frame is not 32-bit and no row is masked, so nothing is written.
    send_fields(2'd3, 2'd3, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(2'd0, 2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);

    // Even rows masked while the frame is not 32-bit: restore still happens.
    load_regs(mode_word(SCAN_EVEN_A, 0, 0, 0, 0), '0, '0, '0, '0);
    send_fields(2'd1, 2'd0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000);
    send_fields(2'd2, 2'd1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000);
    send_fields(2'd3, 2'd3, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    load_regs(mode_word(SCAN_EVEN_B, 0, 0, 0, 0), '0, '0, '0, '0);
    send_fields(2'd0, 2'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0000_0000);

    // Odd rows masked, 32-bit frame: unchanged pixel and untouched result.
    load_regs(mode_word(SCAN_ODD, 1, 0, 0, 0), '0, '0, '0, '0);
    send_fields(2'd0, 2'd1, 32'hFFFF_FFFF, 32'h1111_1111, 32'h0000_0000);
    send_fields(2'd3, 2'd3, 32'h0000_0000, 32'h2222_2222, 32'hFFFF_FFFF);
    send_fields(2'd1, 2'd0, 32'h5555_5555, 32'h3333_3333, 32'h5555_5555);
    send_fields(2'd2, 2'd2, 32'h5555_5555, 32'h4444_4444, 32'hAAAA_AAAA);

    // Wrap blend with the fixed factor and a negative difference.
    load_regs(mode_word(SCAN_OFF, 1, 1, 0, 0),
              blend_word(SEL_SOURCE, SEL_DEST, SEL_FIX, SEL_DEST),
              8'hFF, 32'hFF00_00FF, '0);
    send_fields(2'd0, 2'd0, 32'h80FF_00FF, 32'h0, 32'h1122_3344);
    send_fields(2'd3, 2'd1, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF);

    // Source alpha as the factor; the sum wraps past 255.
    load_regs(mode_word(SCAN_OFF, 1, 1, 0, 0),
              blend_word(SEL_DEST, SEL_ZERO, SEL_SOURCE, SEL_ZERO),
              8'h00, 32'hFF00_0000, '0);
    send_fields(2'd1, 2'd2, 32'h00FF_FFFF, 32'h0, 32'h7F00_0000);

    // Everything on, destination alpha as the factor, full dither matrix.
    load_regs(mode_word(SCAN_OFF, 1, 1, 1, 1),
              blend_word(SEL_SOURCE, SEL_ZERO, SEL_DEST, SEL_SOURCE),
              8'h80, 32'h00FE_FEFE, '1);
    send_fields(2'd2, 2'd3, 32'hFF00_0000, 32'h0, 32'h0000_0001);
    send_fields(2'd0, 2'd1, 32'h0012_3456, 32'h0, 32'hFF65_4321);

    // Dither alone: saturation at the top of the range.
    load_regs(mode_word(SCAN_OFF, 1, 0, 1, 0), '0, '0, '0, '1);
    send_fields(2'd3, 2'd3, 32'h0000_0000, 32'h0, 32'h00FE_FD01);
    send_fields(2'd0, 2'd0, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF);

    // Halve alone; a zero drawn word halves to itself and is not written.
    load_regs(mode_word(SCAN_OFF, 1, 0, 0, 1), '0, '0, '0, '0);
    send_fields(2'd1, 2'd1, 32'h0000_0000, 32'h0, 32'hFF00_00FF);
    send_fields(2'd2, 2'd0, 32'h0000_0001, 32'h0, 32'h0000_0000);

    // Random phases, the first with every register at its maximum.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) load_regs('1, '1, '1, '1, '1);
      else load_random_regs();
      source_busy = (ph % 4 != 1);
      sink_busy = (ph % 4 != 1);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(make_pixel());
    end

    // Drain with the result side open.
    pix_valid <= 1'b0;
    sink_busy = 1'b0;
    waited = 0;
    @(posedge clk);
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
